>>> hw/rtl/irpdt_pkg.sv
// Shared constants and helpers for the infrared pulse-distance transmitter.
package irpdt_pkg;

  localparam int TickCountWidth = 12;
  localparam int DurWidth       = 12;
  localparam int RepeatWidth    = 4;
  localparam int PhaseWidth     = 3;
  localparam int BitPosWidth    = 6;
  localparam int CfgIndexWidth  = 3;

  localparam logic [BitPosWidth-1:0] StopPosition = BitPosWidth'(32);

  localparam logic [PhaseWidth-1:0] PH_IDLE      = 3'd0;
  localparam logic [PhaseWidth-1:0] PH_HEAD_HIGH = 3'd1;
  localparam logic [PhaseWidth-1:0] PH_HEAD_LOW  = 3'd2;
  localparam logic [PhaseWidth-1:0] PH_BIT_HIGH  = 3'd3;
  localparam logic [PhaseWidth-1:0] PH_BIT_LOW   = 3'd4;
  localparam logic [PhaseWidth-1:0] PH_GAP       = 3'd5;

  localparam logic [CfgIndexWidth-1:0] REG_HEADER_HIGH = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_HEADER_LOW  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_ZERO_HIGH   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_ZERO_LOW    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_ONE_HIGH    = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_ONE_LOW     = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_GAP         = 3'd6;
  localparam logic [CfgIndexWidth-1:0] REG_REPEAT      = 3'd7;

  localparam logic [DurWidth-1:0]    HeaderHighReset = 12'd360;
  localparam logic [DurWidth-1:0]    HeaderLowReset  = 12'd180;
  localparam logic [DurWidth-1:0]    ZeroHighReset   = 12'd22;
  localparam logic [DurWidth-1:0]    ZeroLowReset    = 12'd23;
  localparam logic [DurWidth-1:0]    OneHighReset    = 12'd45;
  localparam logic [DurWidth-1:0]    OneLowReset     = 12'd45;
  localparam logic [DurWidth-1:0]    GapReset        = 12'd220;
  localparam logic [RepeatWidth-1:0] RepeatReset     = 4'd6;

  function automatic logic [TickCountWidth-1:0] load_ticks(input logic [DurWidth-1:0] dur);
    return TickCountWidth'(dur);
  endfunction

endpackage

>>> hw/rtl/ir_pulse_distance_transmitter.sv
// Infrared pulse-distance transmitter: frame sequencer with a registered result beat.
// Each accepted input beat gives its result beat on the next cycle. The sequencer state
// updates in a single pass; one input beat per cycle unless a stalled result holds it.
// A result beat waits in the output register while a new input beat is accepted in the
// cycle it drains. Reset is synchronous: it returns the sequencer to idle, empties the
// output register and loads the default timing registers.
module ir_pulse_distance_transmitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // address_byte [7:0], data_byte [15:8]
  input  logic [0:0]  s_tuser,   // kind [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // pin_level [0], busy_res [1], command_dropped [2], zero pad
  input  logic        cfg_we,
  input  logic [irpdt_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [irpdt_pkg::DurWidth-1:0]      cfg_data
);

  logic [irpdt_pkg::DurWidth-1:0]    header_high_ticks;
  logic [irpdt_pkg::DurWidth-1:0]    header_low_ticks;
  logic [irpdt_pkg::DurWidth-1:0]    zero_high_ticks;
  logic [irpdt_pkg::DurWidth-1:0]    zero_low_ticks;
  logic [irpdt_pkg::DurWidth-1:0]    one_high_ticks;
  logic [irpdt_pkg::DurWidth-1:0]    one_low_ticks;
  logic [irpdt_pkg::DurWidth-1:0]    gap_ticks;
  logic [irpdt_pkg::RepeatWidth-1:0] repeat_count;

  logic [irpdt_pkg::PhaseWidth-1:0]     phase, phase_next;
  logic [irpdt_pkg::TickCountWidth-1:0] ticks_left, ticks_left_next;
  logic [irpdt_pkg::BitPosWidth-1:0]    bit_position, bit_position_next;
  logic [irpdt_pkg::RepeatWidth-1:0]    frames_left, frames_left_next;
  logic [31:0]                          frame_word, frame_word_next;

  logic       accept;
  logic       dropped;
  logic       pin_next;
  logic       busy_next;
  logic [7:0] addr;
  logic [7:0] data;

  function automatic logic bit_at(input logic [31:0] word,
                                  input logic [irpdt_pkg::BitPosWidth-1:0] pos);
    if (pos >= irpdt_pkg::StopPosition) begin
      return 1'b1;
    end
    return word[pos[4:0]];
  endfunction

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign addr     = s_tdata[7:0];
  assign data     = s_tdata[15:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      header_high_ticks <= irpdt_pkg::HeaderHighReset;
      header_low_ticks  <= irpdt_pkg::HeaderLowReset;
      zero_high_ticks   <= irpdt_pkg::ZeroHighReset;
      zero_low_ticks    <= irpdt_pkg::ZeroLowReset;
      one_high_ticks    <= irpdt_pkg::OneHighReset;
      one_low_ticks     <= irpdt_pkg::OneLowReset;
      gap_ticks         <= irpdt_pkg::GapReset;
      repeat_count      <= irpdt_pkg::RepeatReset;
    end else if (cfg_we) begin
      case (cfg_index)
        irpdt_pkg::REG_HEADER_HIGH: header_high_ticks <= cfg_data;
        irpdt_pkg::REG_HEADER_LOW:  header_low_ticks  <= cfg_data;
        irpdt_pkg::REG_ZERO_HIGH:   zero_high_ticks   <= cfg_data;
        irpdt_pkg::REG_ZERO_LOW:    zero_low_ticks    <= cfg_data;
        irpdt_pkg::REG_ONE_HIGH:    one_high_ticks    <= cfg_data;
        irpdt_pkg::REG_ONE_LOW:     one_low_ticks     <= cfg_data;
        irpdt_pkg::REG_GAP:         gap_ticks         <= cfg_data;
        irpdt_pkg::REG_REPEAT:      repeat_count      <= cfg_data[irpdt_pkg::RepeatWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next        = phase;
    ticks_left_next   = ticks_left;
    bit_position_next = bit_position;
    frames_left_next  = frames_left;
    frame_word_next   = frame_word;
    dropped           = 1'b0;
    if (s_tuser[0]) begin
      if (phase != irpdt_pkg::PH_IDLE) begin
        dropped = 1'b1;
      end else begin
        frame_word_next   = {~data, data, ~addr, addr};
        frames_left_next  = repeat_count;
        bit_position_next = '0;
        phase_next        = irpdt_pkg::PH_HEAD_HIGH;
        ticks_left_next   = irpdt_pkg::load_ticks(header_high_ticks);
      end
    end else if (phase != irpdt_pkg::PH_IDLE) begin
      if (ticks_left > irpdt_pkg::TickCountWidth'(1)) begin
        ticks_left_next = ticks_left - irpdt_pkg::TickCountWidth'(1);
      end else begin
        case (phase)
          irpdt_pkg::PH_HEAD_HIGH: begin
            phase_next      = irpdt_pkg::PH_HEAD_LOW;
            ticks_left_next = irpdt_pkg::load_ticks(header_low_ticks);
          end
          irpdt_pkg::PH_HEAD_LOW: begin
            if (frames_left == '0) begin
              phase_next      = irpdt_pkg::PH_IDLE;
              ticks_left_next = '0;
            end else begin
              bit_position_next = '0;
              phase_next        = irpdt_pkg::PH_BIT_HIGH;
              ticks_left_next   = irpdt_pkg::load_ticks(frame_word[0] ? one_high_ticks
                                                                      : zero_high_ticks);
            end
          end
          irpdt_pkg::PH_BIT_HIGH: begin
            phase_next      = irpdt_pkg::PH_BIT_LOW;
            ticks_left_next = irpdt_pkg::load_ticks(bit_at(frame_word, bit_position) ?
                                                    one_low_ticks : zero_low_ticks);
          end
          irpdt_pkg::PH_BIT_LOW: begin
            if (bit_position >= irpdt_pkg::StopPosition) begin
              phase_next      = irpdt_pkg::PH_GAP;
              ticks_left_next = irpdt_pkg::load_ticks(gap_ticks);
            end else begin
              bit_position_next = bit_position + irpdt_pkg::BitPosWidth'(1);
              phase_next        = irpdt_pkg::PH_BIT_HIGH;
              ticks_left_next   = irpdt_pkg::load_ticks(
                                    bit_at(frame_word, bit_position_next) ?
                                    one_high_ticks : zero_high_ticks);
            end
          end
          irpdt_pkg::PH_GAP: begin
            frames_left_next  = frames_left - irpdt_pkg::RepeatWidth'(1);
            bit_position_next = '0;
            if (frames_left_next == '0) begin
              phase_next      = irpdt_pkg::PH_IDLE;
              ticks_left_next = '0;
            end else begin
              phase_next      = irpdt_pkg::PH_BIT_HIGH;
              ticks_left_next = irpdt_pkg::load_ticks(frame_word[0] ? one_high_ticks
                                                                    : zero_high_ticks);
            end
          end
          default: begin
            phase_next      = irpdt_pkg::PH_IDLE;
            ticks_left_next = '0;
          end
        endcase
      end
    end
    pin_next  = (phase_next == irpdt_pkg::PH_HEAD_HIGH) ||
                (phase_next == irpdt_pkg::PH_BIT_HIGH);
    busy_next = (phase_next != irpdt_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= irpdt_pkg::PH_IDLE;
      ticks_left   <= '0;
      bit_position <= '0;
      frames_left  <= '0;
      frame_word   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      ticks_left   <= ticks_left_next;
      bit_position <= bit_position_next;
      frames_left  <= frames_left_next;
      frame_word   <= frame_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'b0, dropped, busy_next, pin_next};
    end
  end

endmodule

>>> hw/rtl/irpdt_checker.sv
// Port-level checks for the infrared pulse-distance transmitter, bound to the top level.
module irpdt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // Every accepted input beat yields a result beat in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("result beat missing after accepted input beat");

  // A stalled result beat stays offered.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result beat withdrawn while stalled");

  // The pin is only driven high during a transmission.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> m_tdata[1])
    else $error("pin high while not busy");

  // A command can only be dropped while a transmission is in progress.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> m_tdata[1])
    else $error("command dropped while idle");

  // A dropped command arrived as a start command; a tick never drops anything.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser[0]) |=> !m_tdata[2])
    else $error("tick beat flagged as dropped command");

endmodule

bind ir_pulse_distance_transmitter irpdt_checker u_irpdt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
